### rtl/core/csab_pkg.sv
// Package for the clipped stamp add-or-blank core: item, result and
// configuration word types, codes and default sizes.
// Depends on nothing; used by csab_pixel_alu, the core top and the testbench.
`default_nettype none

package csab_pkg;

  localparam int MAX_IMAGE_WIDTH  = 1024;
  localparam int MAX_IMAGE_HEIGHT = 1024;
  localparam int MAX_STAMP_SIZE   = 64;

  localparam int PIXEL_W   = 32;
  localparam int SIZE_W    = 7;
  localparam int POS_W     = 12;
  localparam int ORIGIN_W  = POS_W + 1;
  localparam int COORD_W   = ORIGIN_W + 1;
  localparam int IMG_DIM_W = 11;
  localparam int COUNT_W   = 13;
  localparam int SCALED_W  = 48;
  localparam int HALF_DIVISOR = 2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ELEMENT = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_BLANK = 1'b1;

  localparam logic RES_READ  = 1'b0;
  localparam logic RES_STAMP = 1'b1;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_FLOOR   = 2'd2;

  localparam logic [IMG_DIM_W-1:0] IMAGE_DIM_RESET = 11'd1024;
  localparam logic signed [PIXEL_W-1:0] MASK_FLOOR_RESET = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]                 kind;
    logic                       stamp_mode;
    logic [SIZE_W-1:0]          stamp_width;
    logic [SIZE_W-1:0]          stamp_height;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [PIXEL_W-1:0]  factor;
    logic signed [PIXEL_W-1:0]  element_value;
    logic [9:0]                 pixel_x;
    logic [9:0]                 pixel_y;
  } item_t;

  typedef struct packed {
    logic                       result_kind;
    logic signed [PIXEL_W-1:0]  pixel_value;
    logic [COUNT_W-1:0]         pixels_changed;
  } result_t;

  typedef struct packed {
    logic [1:0]          index;
    logic [PIXEL_W-1:0]  value;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/csab_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from csab_pkg at the instance.
`default_nettype none

interface csab_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/csab_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module csab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/csab_pixel_alu.sv
// Pixel update: saturating add of a scaled element, or blank value select.
// Depends on csab_pkg.
`default_nettype none

module csab_pixel_alu (
  input  wire logic                                  mode,
  input  wire logic signed [csab_pkg::PIXEL_W-1:0]   pixel,
  input  wire logic signed [csab_pkg::SCALED_W-1:0]  scaled,
  input  wire logic signed [csab_pkg::PIXEL_W-1:0]   factor,
  output logic signed [csab_pkg::PIXEL_W-1:0]        value
);

  localparam int SUM_W = csab_pkg::SCALED_W + 1;

  logic signed [SUM_W-1:0] sum;
  logic                    in_range;

  always_comb begin
    sum = $signed({{(SUM_W - csab_pkg::PIXEL_W){pixel[csab_pkg::PIXEL_W-1]}}, pixel})
        + $signed({scaled[csab_pkg::SCALED_W-1], scaled});
    in_range = (sum[SUM_W-1:csab_pkg::PIXEL_W-1] == '0)
            || (sum[SUM_W-1:csab_pkg::PIXEL_W-1] == '1);
    if (mode == csab_pkg::MODE_BLANK) begin
      value = factor;
    end else if (in_range) begin
      value = sum[csab_pkg::PIXEL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      value = {1'b1, {(csab_pkg::PIXEL_W-1){1'b0}}};
    end else begin
      value = {1'b0, {(csab_pkg::PIXEL_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

### rtl/core/clipped_stamp_add_or_blank_core.sv
// Clipped stamp engine: scaled add or masked blank into a Q16.16 image.
// Channels: item (sink, csab_pkg::item_t), result (source, result_t) and
// cfg (sink, cfg_t) register writes; a word moves when valid and ready meet.
// A header word opens a stamp; its element words follow in row-major order.
// Pixel write and pixel read words address the image directly.
// Sequencing, set by the registered read data of the image RAM:
//   header, pixel write or stray element: taken in idle, item ready stays high;
//   element without result: read, then modify and write back, then idle;
//   pixel read, or the last element of a stamp: read, modify, then a hold
//   state that loads the result word once the output is free.
// Items are handled one at a time, so a read never overlaps a write.
// Reset: registers take their reset values, then a clearing pass writes zero
// to every one of the MAX_IMAGE_WIDTH*MAX_IMAGE_HEIGHT image entries, during
// which item.ready stays low; cfg writes are taken throughout.
// A stalled receiver holds the result word; one further result is kept
// internally, after which item.ready drops until the output frees.
// Depends on csab_pkg, csab_stream_if, csab_ram and csab_pixel_alu.
`default_nettype none

module clipped_stamp_add_or_blank_core #(
  parameter int MAX_IMAGE_WIDTH  = csab_pkg::MAX_IMAGE_WIDTH,
  parameter int MAX_IMAGE_HEIGHT = csab_pkg::MAX_IMAGE_HEIGHT,
  parameter int MAX_STAMP_SIZE   = csab_pkg::MAX_STAMP_SIZE
) (
  input  wire logic       clk,
  input  wire logic       rst,
  csab_stream_if.sink     item,
  csab_stream_if.source   result,
  csab_stream_if.sink     cfg
);

  localparam int DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = csab_pkg::COORD_W;
  localparam int SW     = csab_pkg::SIZE_W;
  localparam int PW     = csab_pkg::PIXEL_W;
  localparam int OW     = csab_pkg::ORIGIN_W;
  localparam int NW     = csab_pkg::COUNT_W;
  localparam int SIZE_MAX_FIELD = (1 << SW) - 1;
  localparam logic [SW-1:0] SIZE_CAP =
    SW'((MAX_STAMP_SIZE > SIZE_MAX_FIELD) ? SIZE_MAX_FIELD : MAX_STAMP_SIZE);
  localparam logic [CW-1:0] X_LIM = CW'(MAX_IMAGE_WIDTH);
  localparam logic [CW-1:0] Y_LIM = CW'(MAX_IMAGE_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_IMAGE_WIDTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state;

  logic [csab_pkg::IMG_DIM_W-1:0] image_width;
  logic [csab_pkg::IMG_DIM_W-1:0] image_height;
  logic signed [PW-1:0]           mask_floor;

  logic                 stamp_active;
  logic                 active_mode;
  logic [SW-1:0]        active_width;
  logic [SW-1:0]        active_height;
  logic signed [OW-1:0] origin_x;
  logic signed [OW-1:0] origin_y;
  logic signed [PW-1:0] active_factor;
  logic [SW-1:0]        element_column;
  logic [SW-1:0]        element_row;
  logic [NW-1:0]        touched_count;

  logic [ADDR_W-1:0] clear_addr;

  logic                                  pend_read;
  logic                                  pend_inside;
  logic [ADDR_W-1:0]                     pend_addr;
  logic signed [csab_pkg::SCALED_W-1:0]  pend_scaled;
  logic                                  pend_above;
  logic                                  pend_finish;
  csab_pkg::result_t                     pend_res;

  logic              res_valid;
  csab_pkg::result_t res_data;

  logic accept;
  logic out_free;

  logic [SW-1:0]        hdr_width;
  logic [SW-1:0]        hdr_height;
  logic [CW-1:0]        elem_x;
  logic [CW-1:0]        elem_y;
  logic                 elem_inside;
  logic [ADDR_W-1:0]    elem_addr;
  logic                 pix_inside;
  logic [ADDR_W-1:0]    pix_addr;
  logic [SW-1:0]        column_next;
  logic                 row_wrap;
  logic [SW-1:0]        row_next;
  logic                 stamp_done;
  logic signed [2*PW-1:0] product;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PW-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PW-1:0]     ram_rdata;
  logic signed [PW-1:0] alu_value;

  logic              elem_write;
  logic [NW-1:0]     touched_upd;
  logic              apply_has_res;
  csab_pkg::result_t apply_res;

  assign item.ready    = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign result.valid  = res_valid;
  assign result.data   = res_data;
  assign accept        = item.valid && item.ready;
  assign out_free      = !res_valid || result.ready;

  // stamp size clamp, element and pixel addresses, stepping and scaling product
  always_comb begin
    hdr_width = (item.data.stamp_width == '0) ? SW'(1)
              : ((item.data.stamp_width > SIZE_CAP) ? SIZE_CAP : item.data.stamp_width);
    hdr_height = (item.data.stamp_height == '0) ? SW'(1)
               : ((item.data.stamp_height > SIZE_CAP) ? SIZE_CAP : item.data.stamp_height);

    elem_x = {origin_x[OW-1], origin_x} + CW'(element_column);
    elem_y = {origin_y[OW-1], origin_y} + CW'(element_row);
    elem_inside = !elem_x[CW-1] && !elem_y[CW-1]
               && (elem_x < CW'(image_width)) && (elem_x < X_LIM)
               && (elem_y < CW'(image_height)) && (elem_y < Y_LIM);
    elem_addr = ADDR_W'(elem_y) * ROW_PITCH + ADDR_W'(elem_x);

    pix_inside = (CW'(item.data.pixel_x) < CW'(image_width))
              && (CW'(item.data.pixel_x) < X_LIM)
              && (CW'(item.data.pixel_y) < CW'(image_height))
              && (CW'(item.data.pixel_y) < Y_LIM);
    pix_addr = ADDR_W'(item.data.pixel_y) * ROW_PITCH + ADDR_W'(item.data.pixel_x);

    column_next = element_column + SW'(1);
    row_wrap    = (column_next >= active_width);
    row_next    = element_row + SW'(1);
    stamp_done  = row_wrap && (row_next >= active_height);

    product = active_factor * item.data.element_value;
  end

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = alu_value;
    ram_raddr = (item.data.kind == csab_pkg::KIND_READ) ? pix_addr : elem_addr;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (accept && item.data.kind == csab_pkg::KIND_WRITE && pix_inside) begin
          ram_we    = 1'b1;
          ram_waddr = pix_addr;
          ram_wdata = item.data.element_value;
        end
      end
      ST_APPLY: begin
        ram_we = elem_write;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  csab_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  csab_pixel_alu u_alu (
    .mode   (active_mode),
    .pixel  (ram_rdata),
    .scaled (pend_scaled),
    .factor (active_factor),
    .value  (alu_value)
  );

  // read-modify-write completion and result build
  always_comb begin
    elem_write  = !pend_read && pend_inside
               && (active_mode == csab_pkg::MODE_ADD || pend_above);
    touched_upd = touched_count + NW'(elem_write);
    apply_has_res = pend_read || pend_finish;
    apply_res = '0;
    if (pend_read) begin
      apply_res.result_kind = csab_pkg::RES_READ;
      apply_res.pixel_value = pend_inside ? ram_rdata : '0;
    end else begin
      apply_res.result_kind    = csab_pkg::RES_STAMP;
      apply_res.pixels_changed = touched_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_addr     <= '0;
      image_width    <= csab_pkg::IMAGE_DIM_RESET;
      image_height   <= csab_pkg::IMAGE_DIM_RESET;
      mask_floor     <= csab_pkg::MASK_FLOOR_RESET;
      stamp_active   <= 1'b0;
      active_mode    <= csab_pkg::MODE_ADD;
      active_width   <= '0;
      active_height  <= '0;
      origin_x       <= '0;
      origin_y       <= '0;
      active_factor  <= '0;
      element_column <= '0;
      element_row    <= '0;
      touched_count  <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          csab_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data.value[csab_pkg::IMG_DIM_W-1:0];
          csab_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data.value[csab_pkg::IMG_DIM_W-1:0];
          csab_pkg::REG_MASK_FLOOR:   mask_floor   <= cfg.data.value;
          default: ;
        endcase
      end

      if (state == ST_HOLD && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + ADDR_W'(1);
          if (clear_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (item.data.kind)
              csab_pkg::KIND_HEADER: begin
                active_mode    <= item.data.stamp_mode;
                active_width   <= hdr_width;
                active_height  <= hdr_height;
                active_factor  <= item.data.factor;
                element_column <= '0;
                element_row    <= '0;
                touched_count  <= '0;
                stamp_active   <= 1'b1;
                if (item.data.stamp_mode == csab_pkg::MODE_ADD) begin
                  origin_x <= {item.data.pos_x[csab_pkg::POS_W-1], item.data.pos_x}
                            - OW'(hdr_width / csab_pkg::HALF_DIVISOR);
                  origin_y <= {item.data.pos_y[csab_pkg::POS_W-1], item.data.pos_y}
                            - OW'(hdr_height / csab_pkg::HALF_DIVISOR);
                end else begin
                  origin_x <= {item.data.pos_x[csab_pkg::POS_W-1], item.data.pos_x};
                  origin_y <= {item.data.pos_y[csab_pkg::POS_W-1], item.data.pos_y};
                end
              end
              csab_pkg::KIND_ELEMENT: begin
                if (stamp_active) begin
                  state <= ST_APPLY;
                  if (row_wrap) begin
                    element_column <= '0;
                    element_row    <= stamp_done ? '0 : row_next;
                  end else begin
                    element_column <= column_next;
                  end
                  if (stamp_done) begin
                    stamp_active <= 1'b0;
                  end
                end
              end
              csab_pkg::KIND_READ: begin
                state <= ST_APPLY;
              end
              default: ;
            endcase
          end
        end
        ST_APPLY: begin
          touched_count <= touched_upd;
          state         <= apply_has_res ? ST_HOLD : ST_IDLE;
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      pend_read   <= (item.data.kind == csab_pkg::KIND_READ);
      pend_inside <= (item.data.kind == csab_pkg::KIND_READ) ? pix_inside : elem_inside;
      pend_addr   <= elem_addr;
      pend_scaled <= product[2*PW-1:16];
      pend_above  <= (item.data.element_value > mask_floor);
      pend_finish <= stamp_done;
    end
    if (state == ST_APPLY) begin
      pend_res <= apply_res;
    end
    if (state == ST_HOLD && out_free) begin
      res_data <= pend_res;
    end
  end

`ifndef SYNTHESIS
  a_clear_blocks_items: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !item.ready)
    else $error("item taken during clearing pass");

  a_apply_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |-> $past(state) == ST_IDLE && $past(accept))
    else $error("modify cycle without an accepted word");

  a_read_word_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.result_kind == csab_pkg::RES_READ |-> res_data.pixels_changed == '0)
    else $error("read result carries a touch count");

  a_stamp_word_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.result_kind == csab_pkg::RES_STAMP |-> res_data.pixel_value == '0)
    else $error("stamp result carries pixel data");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for clipped_stamp_add_or_blank_core: keeps its own model of the
// image and the stamp engine, then checks every result word against it.
// Depends on csab_pkg, csab_stream_if and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csab_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam longint PIX_MAX = 64'sd2147483647;
  localparam longint PIX_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst;

  csab_stream_if #(.payload_t(item_t)) item_ch ();
  csab_stream_if #(.payload_t(result_t)) result_ch ();
  csab_stream_if #(.payload_t(cfg_t)) cfg_ch ();

  clipped_stamp_add_or_blank_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  // Image model and stamp engine state
  logic signed [31:0] image_copy [int];
  int cfg_width = 1024;
  int cfg_height = 1024;
  logic signed [31:0] floor_q = MASK_FLOOR_RESET;
  bit stamp_open;
  logic active_mode;
  int st_w, st_h, org_x, org_y, col, row;
  int unsigned touched;
  logic signed [31:0] st_factor;

  item_t pending_items [$];
  result_t awaited_results [$];
  int mismatches;
  int cycles;
  bit item_fired;
  int burst_left, gap_left, hold_left;

  function automatic int eff_w();
    return (cfg_width > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH : cfg_width;
  endfunction

  function automatic int eff_h();
    return (cfg_height > MAX_IMAGE_HEIGHT) ? MAX_IMAGE_HEIGHT : cfg_height;
  endfunction

  function automatic int stamp_dim(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_STAMP_SIZE) return MAX_STAMP_SIZE;
    return int'(v);
  endfunction

  function automatic bit on_image(int x, int y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic logic signed [31:0] pixel_at(int a);
    if (image_copy.exists(a)) return image_copy[a];
    return '0;
  endfunction

  task automatic stamp_engine_step(item_t it);
    result_t r;
    int x, y, a;
    longint prod, total;
    r = '0;
    case (it.kind)
      KIND_HEADER: begin
        active_mode = it.stamp_mode;
        st_w = stamp_dim(it.stamp_width);
        st_h = stamp_dim(it.stamp_height);
        st_factor = it.factor;
        org_x = int'(it.pos_x);
        org_y = int'(it.pos_y);
        if (active_mode == MODE_ADD) begin
          org_x -= st_w / HALF_DIVISOR;
          org_y -= st_h / HALF_DIVISOR;
        end
        col = 0;
        row = 0;
        touched = 0;
        stamp_open = 1'b1;
      end
      KIND_ELEMENT: begin
        if (stamp_open) begin
          x = org_x + col;
          y = org_y + row;
          if (on_image(x, y)) begin
            a = y * MAX_IMAGE_WIDTH + x;
            if (active_mode == MODE_ADD) begin
              prod = longint'(st_factor) * longint'(it.element_value);
              total = longint'(pixel_at(a)) + (prod >>> 16);
              if (total > PIX_MAX) total = PIX_MAX;
              if (total < PIX_MIN) total = PIX_MIN;
              image_copy[a] = total[31:0];
              touched++;
            end else if (it.element_value > floor_q) begin
              image_copy[a] = st_factor;
              touched++;
            end
          end
          col++;
          if (col >= st_w) begin
            col = 0;
            row++;
            if (row >= st_h) begin
              stamp_open = 1'b0;
              row = 0;
              r.result_kind = RES_STAMP;
              r.pixels_changed = touched[COUNT_W-1:0];
              awaited_results.push_back(r);
            end
          end
        end
      end
      KIND_WRITE: begin
        if (on_image(int'(it.pixel_x), int'(it.pixel_y)))
          image_copy[int'(it.pixel_y) * MAX_IMAGE_WIDTH + int'(it.pixel_x)] = it.element_value;
      end
      default: begin
        r.result_kind = RES_READ;
        if (on_image(int'(it.pixel_x), int'(it.pixel_y)))
          r.pixel_value = pixel_at(int'(it.pixel_y) * MAX_IMAGE_WIDTH + int'(it.pixel_x));
        awaited_results.push_back(r);
      end
    endcase
  endtask

  // Sample handshakes, update the model and check result words
  always @(posedge clk) begin
    result_t want, got;
    cycles++;
    item_fired = item_ch.valid && item_ch.ready;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.index)
        REG_IMAGE_WIDTH: cfg_width = int'(cfg_ch.data.value[IMG_DIM_W-1:0]);
        REG_IMAGE_HEIGHT: cfg_height = int'(cfg_ch.data.value[IMG_DIM_W-1:0]);
        REG_MASK_FLOOR: floor_q = cfg_ch.data.value;
        default: ;
      endcase
    end
    if (result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: result_kind %0d pixel_value %h pixels_changed %0d",
               got.result_kind, got.pixel_value, got.pixels_changed);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
          mismatches++;
        end
        if (got.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
          mismatches++;
        end
        if (got.pixels_changed !== want.pixels_changed) begin
          $error("pixels_changed: expected %0d, got %0d",
                 want.pixels_changed, got.pixels_changed);
          mismatches++;
        end
      end
    end
    if (item_fired) stamp_engine_step(item_ch.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Item driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fired) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        item_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        item_ch.data <= pending_items.pop_front();
        item_ch.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: rotates among four stall styles: always ready, regular, random and held
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      case ((cycles / 257) % 4)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= (cycles % 3) != 0;
        2: result_ch.ready <= $urandom_range(0, 9) < 6;
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(3, 12);
            result_ch.ready <= 1'b0;
          end else begin
            result_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic item_t random_item(logic [1:0] k);
    logic [127:0] raw;
    item_t it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  task automatic push_header(logic mode, logic [SIZE_W-1:0] w, h, int px, py,
                             logic [31:0] f);
    item_t it;
    it = random_item(KIND_HEADER);
    it.stamp_mode = mode;
    it.stamp_width = w;
    it.stamp_height = h;
    it.pos_x = px[POS_W-1:0];
    it.pos_y = py[POS_W-1:0];
    it.factor = f;
    pending_items.push_back(it);
  endtask

  task automatic push_element(logic [31:0] v);
    item_t it;
    it = random_item(KIND_ELEMENT);
    it.element_value = v;
    pending_items.push_back(it);
  endtask

  task automatic push_pixel(logic [1:0] k, logic [9:0] x, y, logic [31:0] v);
    item_t it;
    it = random_item(k);
    it.pixel_x = x;
    it.pixel_y = y;
    it.element_value = v;
    pending_items.push_back(it);
  endtask

  function automatic logic [9:0] pick_coord(int lim);
    if (lim == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 2))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000);
      default: return 32'(-int'($urandom_range(1, 32'h0004_0000)));
    endcase
  endfunction

  task automatic queue_stamp(input logic mode, input logic [SIZE_W-1:0] w, h,
                             input int px, py, input logic [31:0] f, input int keep,
                             output int pushed);
    int total;
    total = stamp_dim(w) * stamp_dim(h);
    if (keep >= 0 && keep < total) total = keep;
    push_header(mode, w, h, px, py, f);
    pushed = 1;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_pixel(KIND_READ, pick_coord(eff_w()), pick_coord(eff_h()), $urandom());
        pushed++;
      end
      push_element(pick_q16());
      pushed++;
    end
  endtask

  task automatic random_traffic(int budget);
    int done, n, r, ew, eh, keep, px, py;
    logic mode;
    logic [SIZE_W-1:0] w, h;
    logic [9:0] x, y;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 99);
      ew = eff_w();
      eh = eff_h();
      if (r < 75) begin
        mode = $urandom_range(0, 1);
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(0, 127);
          h = $urandom_range(0, 1);
          if ($urandom_range(0, 1)) {w, h} = {h, w};
        end
        if (ew > 0 && eh > 0 && $urandom_range(0, 7) != 0) begin
          px = int'($urandom_range(0, ew + 3)) - 2;
          py = int'($urandom_range(0, eh + 3)) - 2;
        end else begin
          px = int'($urandom_range(0, 4095)) - 2048;
          py = int'($urandom_range(0, 4095)) - 2048;
        end
        keep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : -1;
        queue_stamp(mode, w, h, px, py, pick_q16(), keep, n);
        push_pixel(KIND_READ, px[9:0], py[9:0], $urandom());
        done += n + 1;
      end else if (r < 80) begin
        push_element($urandom());
      end else if (r < 90) begin
        x = pick_coord(ew);
        y = pick_coord(eh);
        push_pixel(KIND_WRITE, x, y, $urandom());
        push_pixel(KIND_READ, x, y, $urandom());
        done += 2;
      end else begin
        push_pixel(KIND_READ, pick_coord(ew), pick_coord(eh), $urandom());
        done++;
      end
    end
  endtask

  task automatic wait_quiet();
    while (pending_items.size() != 0 || item_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_ch.data <= '{index: idx, value: v};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic set_config(int w, int h, logic [31:0] flr);
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    write_reg(REG_MASK_FLOOR, flr);
    write_reg(REG_SPARE, $urandom());
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  int phase_w [6] = '{16, 1, 2047, 1024, 37, 0};
  int phase_h [6] = '{12, 1024, 0, 1024, 1, 7};
  logic [31:0] phase_floor [6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                   32'hFFFF_0000, 32'h8000_0000};

  initial begin
    int n;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;

    // Saturation, blank threshold, stray element, clipped and abandoned stamps
    push_pixel(KIND_READ, 10'd0, 10'd0, 32'h0);
    push_pixel(KIND_READ, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    push_pixel(KIND_WRITE, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
    push_pixel(KIND_READ, 10'd1023, 10'd1023, 32'h0);
    push_pixel(KIND_WRITE, 10'd5, 10'd5, 32'h7FFF_0000);
    push_header(MODE_ADD, 7'd1, 7'd1, 5, 5, 32'h7FFF_FFFF);
    push_element(32'h7FFF_FFFF);
    push_pixel(KIND_READ, 10'd5, 10'd5, 32'h0);
    push_pixel(KIND_WRITE, 10'd6, 10'd6, 32'h8000_0000);
    push_header(MODE_ADD, 7'd1, 7'd1, 6, 6, 32'h8000_0000);
    push_element(32'h7FFF_FFFF);
    push_pixel(KIND_READ, 10'd6, 10'd6, 32'h0);
    push_element(32'h1234_5678);
    push_header(MODE_BLANK, 7'd0, 7'd0, 0, 0, 32'hFFFF_FFFF);
    push_element(32'h7FFF_FFFF);
    push_pixel(KIND_READ, 10'd0, 10'd0, 32'h0);
    push_header(MODE_BLANK, 7'd1, 7'd1, 0, 0, 32'h1234_5678);
    push_element(32'h8000_0000);
    push_header(MODE_ADD, 7'd2, 7'd1, -2048, 2047, 32'h0000_0001);
    push_element(32'h7FFF_FFFF);
    push_element(32'h8000_0000);
    push_header(MODE_ADD, 7'd2, 7'd2, 2, 2, 32'h0001_0000);
    push_element(32'h0003_0000);
    push_header(MODE_BLANK, 7'd1, 7'd2, 1023, 1022, 32'h0000_0005);
    push_element(32'h0000_0001);
    push_pixel(KIND_READ, 10'd1023, 10'd1022, 32'h0);
    push_element(32'h0000_0002);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      set_config(phase_w[p], phase_h[p], (p == 3) ? $urandom() : phase_floor[p]);
      random_traffic(70);
      if (p == 3) begin
        queue_stamp(MODE_ADD, 7'd8, 7'd8, 500, 500, 32'h0001_0000, -1, n);
        push_pixel(KIND_READ, 10'd500, 10'd500, 32'h0);
      end
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
